// File: hdl/wpc_pkg.sv
// ----------------------------------------------------------------------------
// Whirlpool compression package
// Shared widths, S-box and round helpers for the compression datapath.
// ----------------------------------------------------------------------------
package wpc_pkg;

  localparam int unsigned WORD_W    = 64;
  localparam int unsigned NUM_WORDS = 8;
  localparam int unsigned ROUNDS_DEF = 10;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [NUM_WORDS-1:0] block_t;

  localparam logic [7:0] GF_POLY = 8'h1d;
  localparam logic [7:0] GF_MSB  = 8'h80;

  function automatic logic [3:0] mini_e(input logic [3:0] x);
    logic [3:0] r;
    unique case (x)
      4'h0: r = 4'h1; 4'h1: r = 4'hb; 4'h2: r = 4'h9; 4'h3: r = 4'hc;
      4'h4: r = 4'hd; 4'h5: r = 4'h6; 4'h6: r = 4'hf; 4'h7: r = 4'h3;
      4'h8: r = 4'he; 4'h9: r = 4'h8; 4'ha: r = 4'h7; 4'hb: r = 4'h4;
      4'hc: r = 4'ha; 4'hd: r = 4'h2; 4'he: r = 4'h5; default: r = 4'h0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] mini_ei(input logic [3:0] x);
    logic [3:0] r;
    unique case (x)
      4'h1: r = 4'h0; 4'hb: r = 4'h1; 4'h9: r = 4'h2; 4'hc: r = 4'h3;
      4'hd: r = 4'h4; 4'h6: r = 4'h5; 4'hf: r = 4'h6; 4'h3: r = 4'h7;
      4'he: r = 4'h8; 4'h8: r = 4'h9; 4'h7: r = 4'ha; 4'h4: r = 4'hb;
      4'ha: r = 4'hc; 4'h2: r = 4'hd; 4'h5: r = 4'he; default: r = 4'hf;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] mini_r(input logic [3:0] x);
    logic [3:0] r;
    unique case (x)
      4'h0: r = 4'h7; 4'h1: r = 4'hc; 4'h2: r = 4'hb; 4'h3: r = 4'hd;
      4'h4: r = 4'he; 4'h5: r = 4'h4; 4'h6: r = 4'h9; 4'h7: r = 4'hf;
      4'h8: r = 4'h6; 4'h9: r = 4'h3; 4'ha: r = 4'h8; 4'hb: r = 4'ha;
      4'hc: r = 4'h2; 4'hd: r = 4'h5; 4'he: r = 4'h1; default: r = 4'h0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [3:0] u, l, t;
    u = mini_e(x[7:4]);
    l = mini_ei(x[3:0]);
    t = mini_r(u ^ l);
    return {mini_e(u ^ t), mini_ei(l ^ t)};
  endfunction

  function automatic logic [7:0] gf_dbl(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (((v & GF_MSB) != 8'h00) ? GF_POLY : 8'h00);
  endfunction

  // column j of the circulant row, for an S-box output s
  function automatic word_t mix_entry(input logic [7:0] s, input logic [2:0] j);
    logic [7:0] x2, x4, x8;
    word_t w;
    x2 = gf_dbl(s);
    x4 = gf_dbl(x2);
    x8 = gf_dbl(x4);
    w = {s, s, x4, s, x8, x4 ^ s, x2, x8 ^ s};
    return (w >> (8 * j)) | (w << (WORD_W - 8 * j));
  endfunction

  function automatic word_t rnd_const(input logic [3:0] r);
    word_t acc;
    logic [7:0] base;
    acc = '0;
    base = 8'({r, 3'b000} - 8'd8);
    for (int j = 0; j < NUM_WORDS; j++) begin
      acc[WORD_W-1-8*j -: 8] = sbox(8'(base + 8'(j)));
    end
    return acc;
  endfunction

endpackage

// File: hdl/wpc_lane.sv
// ----------------------------------------------------------------------------
// Whirlpool round lane
// Computes one 64-bit output word of a round: eight S-box/mix terms plus key.
// ----------------------------------------------------------------------------
module wpc_lane #(
  parameter int unsigned LANE = 0
) (
  input  wpc_pkg::block_t src,
  input  wpc_pkg::word_t  rk,
  output wpc_pkg::word_t  dst
);
  import wpc_pkg::*;

  always_comb begin
    dst = rk;
    for (int j = 0; j < NUM_WORDS; j++) begin
      dst = dst ^ mix_entry(sbox(src[(LANE - j + NUM_WORDS) % NUM_WORDS][WORD_W-1-8*j -: 8]),
                            3'(j));
    end
  end

endmodule

// File: hdl/wpc_round.sv
// ----------------------------------------------------------------------------
// Whirlpool round
// Eight lanes side by side; merge their words into one round output.
// ----------------------------------------------------------------------------
module wpc_round (
  input  wpc_pkg::block_t src,
  input  wpc_pkg::block_t rk,
  output wpc_pkg::block_t dst
);
  import wpc_pkg::*;

  for (genvar i = 0; i < NUM_WORDS; i++) begin : g_lane
    wpc_lane #(.LANE(i)) u_lane (.src(src), .rk(rk[i]), .dst(dst[i]));
  end

endmodule

// File: hdl/whirlpool_compress_top.sv
// After a request is accepted, ROUNDS rounds run before the result is valid (10 by default).
// One key round and one state round per cycle on two round instances reused across rounds;
// a new block waits until the current one is done, each block needing the prior chaining value.
// A new request is taken no earlier than the edge at which the previous result leaves.
// Reset clears the chaining value, the round sequencer and the output valid.
// ----------------------------------------------------------------------------
// Whirlpool compression top
// Miyaguchi-Preneel compression over the W cipher, ROUNDS rounds (ten by default).
// ----------------------------------------------------------------------------
module whirlpool_compress_top #(
  parameter int unsigned ROUNDS = wpc_pkg::ROUNDS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          new_message,
  input  wpc_pkg::word_t msg_word_0, msg_word_1, msg_word_2, msg_word_3,
  input  wpc_pkg::word_t msg_word_4, msg_word_5, msg_word_6, msg_word_7,
  output logic          out_valid,
  input  logic          out_stall,
  output wpc_pkg::word_t hash_word_0, hash_word_1, hash_word_2, hash_word_3,
  output wpc_pkg::word_t hash_word_4, hash_word_5, hash_word_6, hash_word_7
);
  import wpc_pkg::*;

  localparam int unsigned RW = $clog2(ROUNDS + 1);

  block_t chain, key, st, msg, key_rnd, st_rnd, rc, res;
  logic busy;
  logic [RW-1:0] rnd;
  logic in_acc, done;

  assign done     = busy && (rnd == RW'(ROUNDS));
  assign in_stall = busy || (out_valid && out_stall);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    rc = '0;
    rc[0] = rnd_const(4'(rnd));
  end

  wpc_round u_key (.src(key), .rk(rc), .dst(key_rnd));
  wpc_round u_st  (.src(st), .rk(key_rnd), .dst(st_rnd));

  always_comb begin
    for (int i = 0; i < NUM_WORDS; i++) res[i] = chain[i] ^ st_rnd[i] ^ msg[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rnd <= '0;
      out_valid <= 1'b0;
      chain <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (in_acc) begin
        busy <= 1'b1;
        rnd <= RW'(1);
        msg <= {msg_word_7, msg_word_6, msg_word_5, msg_word_4,
                msg_word_3, msg_word_2, msg_word_1, msg_word_0};
        for (int i = 0; i < NUM_WORDS; i++) begin
          key[i] <= new_message ? '0 : chain[i];
        end
        st <= {msg_word_7, msg_word_6, msg_word_5, msg_word_4,
               msg_word_3, msg_word_2, msg_word_1, msg_word_0}
              ^ (new_message ? block_t'('0) : chain);
        if (new_message) chain <= '0;
      end else if (busy) begin
        key <= key_rnd;
        st  <= st_rnd;
        rnd <= rnd + RW'(1);
        if (done) begin
          busy <= 1'b0;
          chain <= res;
          out_valid <= 1'b1;
        end
      end
    end
  end

  assign hash_word_0 = chain[0];
  assign hash_word_1 = chain[1];
  assign hash_word_2 = chain[2];
  assign hash_word_3 = chain[3];
  assign hash_word_4 = chain[4];
  assign hash_word_5 = chain[5];
  assign hash_word_6 = chain[6];
  assign hash_word_7 = chain[7];

endmodule

// File: tb/whirlpool_compress_top_test.sv
// ----------------------------------------------------------------------------
// Whirlpool compression testbench
// Drives message blocks through the valid/stall request channel with random
// gaps and output stalls, and checks every chaining value against a predictor
// of the ten-round W cipher in Miyaguchi-Preneel mode.
// ----------------------------------------------------------------------------
module whirlpool_compress_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import wpc_pkg::*;

  localparam int unsigned NUM_RANDOM = 1500;
  localparam int unsigned NUM_ROWS   = 12;

  typedef struct {
    logic   fresh;
    block_t msg;
  } blk_req_t;

  typedef struct {
    logic   has_exp;
    block_t exp;
  } row_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_stall;
  logic   new_message = 1'b0;
  block_t msg = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  block_t hash;

  word_t  mix_lut [8][256];
  word_t  rc_lut [ROUNDS_DEF+1];
  block_t chain_model;
  block_t chain_queue [$];
  int     fail_count = 0;
  int     out_wait = 0;

  always #1 clk = ~clk;

  whirlpool_compress_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .new_message(new_message),
    .msg_word_0(msg[0]), .msg_word_1(msg[1]), .msg_word_2(msg[2]), .msg_word_3(msg[3]),
    .msg_word_4(msg[4]), .msg_word_5(msg[5]), .msg_word_6(msg[6]), .msg_word_7(msg[7]),
    .out_valid(out_valid), .out_stall(out_stall),
    .hash_word_0(hash[0]), .hash_word_1(hash[1]), .hash_word_2(hash[2]),
    .hash_word_3(hash[3]), .hash_word_4(hash[4]), .hash_word_5(hash[5]),
    .hash_word_6(hash[6]), .hash_word_7(hash[7])
  );

  function automatic logic [7:0] gf_twice(logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1d : 8'h00);
  endfunction

  function automatic logic [3:0] nib(logic [63:0] tab, logic [3:0] i);
    return tab[63-4*i -: 4];
  endfunction

  task automatic build_luts();
    logic [63:0] e_tab, r_tab, ei_tab;
    logic [3:0]  u, l, t;
    logic [7:0]  s, x2, x4, x8;
    word_t       w, acc;
    logic [7:0]  base;
    e_tab = 64'h1B9CD6F3E874A250;
    r_tab = 64'h7CBDE49F638A2510;
    ei_tab = '0;
    for (int i = 0; i < 16; i++) ei_tab[63-4*nib(e_tab, 4'(i)) -: 4] = 4'(i);
    for (int i = 0; i < 256; i++) begin
      u = nib(e_tab, 4'(i >> 4));
      l = nib(ei_tab, 4'(i));
      t = nib(r_tab, u ^ l);
      s = {nib(e_tab, u ^ t), nib(ei_tab, l ^ t)};
      x2 = gf_twice(s);
      x4 = gf_twice(x2);
      x8 = gf_twice(x4);
      w = {s, s, x4, s, x8, x4 ^ s, x2, x8 ^ s};
      for (int j = 0; j < 8; j++) begin
        mix_lut[j][i] = w;
        w = {w[7:0], w[63:8]};
      end
    end
    rc_lut[0] = '0;
    for (int r = 1; r <= ROUNDS_DEF; r++) begin
      base = 8'(8 * (r - 1));
      acc = '0;
      for (int j = 0; j < 8; j++)
        acc ^= mix_lut[j][8'(base + j)] & (64'hff00000000000000 >> (8 * j));
      rc_lut[r] = acc;
    end
  endtask

  function automatic block_t w_round(block_t src, block_t rk);
    block_t dst;
    word_t  w;
    for (int i = 0; i < 8; i++) begin
      dst[i] = rk[i];
      for (int j = 0; j < 8; j++) begin
        w = src[(i - j + 8) % 8];
        dst[i] ^= mix_lut[j][w[63-8*j -: 8]];
      end
    end
    return dst;
  endfunction

  function automatic block_t compress_block(logic fresh, block_t m);
    block_t k, st, rc;
    if (fresh) chain_model = '0;
    k = chain_model;
    st = m ^ k;
    rc = '0;
    for (int r = 1; r <= ROUNDS_DEF; r++) begin
      rc[0] = rc_lut[r];
      k = w_round(k, rc);
      st = w_round(st, k);
    end
    chain_model ^= st ^ m;
    return chain_model;
  endfunction

  task automatic report_mismatch(int idx, word_t got, word_t exp);
    $display("hash mismatch word %0d: got %h expected %h", idx, got, exp);
    fail_count++;
  endtask

  task automatic send_block(blk_req_t req, logic has_exp, block_t exp);
    block_t pred;
    int     gap;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pred = compress_block(req.fresh, req.msg);
    if (has_exp && pred !== exp) begin
      $display("predictor disagrees with typed-in hash");
      fail_count++;
    end
    chain_queue.push_back(has_exp ? exp : pred);
    in_valid <= 1'b1;
    new_message <= req.fresh;
    msg <= req.msg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic block_t rand_block();
    block_t b;
    for (int i = 0; i < 8; i++) b[i] = {$urandom, $urandom};
    return b;
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (chain_queue.size() == 0) begin
        $display("hash result with no request pending");
        fail_count++;
      end else begin
        for (int i = 0; i < 8; i++)
          if (hash[i] !== chain_queue[0][i]) report_mismatch(i, hash[i], chain_queue[0][i]);
        void'(chain_queue.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (out_valid && !out_stall) out_wait = $urandom_range(0, 5);
    else if (out_valid && out_wait > 0) out_wait--;
    out_stall <= (out_wait > 0);
  end

  initial begin
    row_t     rows [NUM_ROWS];
    blk_req_t req;
    build_luts();
    chain_model = '0;
    for (int i = 0; i < NUM_ROWS; i++) rows[i].has_exp = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < NUM_ROWS; i++) begin
      req.fresh = (i == 0 || i == 3 || i == 7) ? 1'b1 : (i % 2 == 1);
      case (i)
        0: begin
          req.msg = '0;
          req.msg[0] = 64'h8000000000000000;
        end
        1, 2: req.msg = '0;
        3, 4: req.msg = '1;
        5: req.msg = {8{64'h0123456789abcdef}};
        6: req.msg = {8{64'h5555555555555555}};
        7: req.msg = {8{64'haaaaaaaaaaaaaaaa}};
        default: req.msg = rand_block();
      endcase
      send_block(req, rows[i].has_exp, rows[i].exp);
    end
    for (int n = 0; n < NUM_RANDOM; n++) begin
      req.fresh = ($urandom_range(0, 7) == 0);
      req.msg = rand_block();
      send_block(req, 1'b0, '0);
    end
    in_valid <= 1'b0;
    while (chain_queue.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fail_count == 0) $display("whirlpool_compress_top_test: PASS");
    else $display("whirlpool_compress_top_test: FAIL");
    $finish;
  end

  initial begin
    #400000;
    $display("whirlpool_compress_top_test: FAIL");
    $finish;
  end

endmodule
